@@ design/lkv_pkg.sv @@
package lkv_pkg;

  localparam int N_ENTRIES  = 16;
  localparam int RANK_W     = $clog2(N_ENTRIES);
  localparam int OCC_W      = $clog2(N_ENTRIES + 1);
  localparam int KEY_W      = 64;
  localparam int VAL_W      = 64;
  localparam int CNT_W      = 32;
  localparam int CAP_W      = 5;
  localparam int IN_DATA_W  = 128;
  localparam int OUT_DATA_W = 192;
  localparam int OUT_USER_W = 2;

  localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(16);

  typedef enum logic {
    FUNC_GET = 1'b0,
    FUNC_PUT = 1'b1
  } func_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_LOOK,
    S_UPD
  } state_t;

  typedef struct packed {
    logic              look;
    logic              upd;
    logic              put;
    logic              hit;
    logic              evict;
    logic [KEY_W-1:0]  key;
    logic [VAL_W-1:0]  value;
    logic [RANK_W-1:0] last_rank;
    logic [RANK_W-1:0] hit_rank;
  } lkv_ctrl_t;

  typedef struct packed {
    logic              hit;
    logic [RANK_W-1:0] rank;
    logic [VAL_W-1:0]  rd;
    logic [KEY_W-1:0]  evk;
  } lkv_link_t;

  typedef struct packed {
    logic valid;
    logic match;
    logic vict;
  } lkv_stat_t;

endpackage

@@ design/lkv_cell.sv @@
module lkv_cell (
  input  logic               clk,
  input  logic               rst_n,
  input  lkv_pkg::lkv_ctrl_t ctrl,
  input  lkv_pkg::lkv_link_t link_in,
  output lkv_pkg::lkv_link_t link_out,
  input  logic               taken_in,
  output logic               taken_out,
  output lkv_pkg::lkv_stat_t stat
);

  logic                       valid_r, valid_nxt;
  logic [lkv_pkg::RANK_W-1:0] rank_r, rank_nxt;
  logic [lkv_pkg::KEY_W-1:0]  key_r, key_nxt;
  logic [lkv_pkg::VAL_W-1:0]  value_r, value_nxt;
  logic                       match_r;
  logic                       vict_r;
  logic                       match;
  logic                       vict;
  logic                       ev_me;
  logic                       free;
  logic                       mine;

  assign match = valid_r && (key_r == ctrl.key);
  assign vict  = valid_r && (rank_r == ctrl.last_rank);

  always_comb begin
    link_out.hit  = link_in.hit | match;
    link_out.rank = link_in.rank | (match ? rank_r : '0);
    link_out.rd   = link_in.rd | (match ? value_r : '0);
    link_out.evk  = link_in.evk | (vict ? key_r : '0);
  end

  assign ev_me     = ctrl.evict && vict_r;
  assign free      = !valid_r || ev_me;
  assign mine      = free && !taken_in;
  assign taken_out = taken_in || free;

  always_comb begin
    valid_nxt = valid_r;
    rank_nxt  = rank_r;
    key_nxt   = key_r;
    value_nxt = value_r;
    if (ctrl.upd) begin
      if (ctrl.hit) begin
        if (match_r) begin
          rank_nxt = '0;
          if (ctrl.put) begin
            value_nxt = ctrl.value;
          end
        end else if (valid_r && (rank_r < ctrl.hit_rank)) begin
          rank_nxt = rank_r + 1'b1;
        end
      end else if (ctrl.put) begin
        if (mine) begin
          valid_nxt = 1'b1;
          key_nxt   = ctrl.key;
          value_nxt = ctrl.value;
          rank_nxt  = '0;
        end else if (ev_me) begin
          valid_nxt = 1'b0;
          rank_nxt  = '0;
        end else if (valid_r) begin
          rank_nxt = rank_r + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      rank_r  <= '0;
    end else begin
      valid_r <= valid_nxt;
      rank_r  <= rank_nxt;
    end
  end

  always_ff @(posedge clk) begin
    key_r   <= key_nxt;
    value_r <= value_nxt;
    if (ctrl.look) begin
      match_r <= match;
      vict_r  <= vict;
    end
  end

  assign stat.valid = valid_r;
  assign stat.match = match_r;
  assign stat.vict  = vict_r;

endmodule

@@ design/lru_key_value_cache.sv @@
// A transaction is accepted only in the idle state; its result is registered in the update state.
// Each transaction compares along the cell chain, then updates; the next is accepted after that.
// A finished result waits in the output register; the next transaction is accepted meanwhile.
// Synchronous active-low reset empties every cell, clears occupancy and both counters,
// and sets the capacity register to sixteen.
module lru_key_value_cache (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_wen,
  input  logic [lkv_pkg::CAP_W-1:0]      cfg_wdata,   // capacity
  input  logic                           in_tvalid,
  output logic                           in_tready,
  input  logic [lkv_pkg::IN_DATA_W-1:0]  in_tdata,    // key, value
  input  logic                           in_tuser,    // func
  output logic                           out_tvalid,
  input  logic                           out_tready,
  output logic [lkv_pkg::OUT_DATA_W-1:0] out_tdata,   // read_value, evicted_key, hits_total,
                                                      // misses_total
  output logic [lkv_pkg::OUT_USER_W-1:0] out_tuser    // hit, evicted
);

  lkv_pkg::state_t state_r, state_nxt;

  logic [lkv_pkg::CAP_W-1:0]  cap_r;
  logic [lkv_pkg::OCC_W-1:0]  occ_r;
  logic [lkv_pkg::CNT_W-1:0]  hits_r;
  logic [lkv_pkg::CNT_W-1:0]  misses_r;
  logic                       put_r;
  logic [lkv_pkg::KEY_W-1:0]  key_r;
  logic [lkv_pkg::VAL_W-1:0]  value_r;
  logic                       hit_r;
  logic [lkv_pkg::RANK_W-1:0] hit_rank_r;
  logic [lkv_pkg::VAL_W-1:0]  rd_r;
  logic [lkv_pkg::KEY_W-1:0]  evk_r;
  logic                       out_valid_r;
  logic [lkv_pkg::OUT_DATA_W-1:0] out_data_r;
  logic [lkv_pkg::OUT_USER_W-1:0] out_user_r;

  logic [lkv_pkg::OCC_W-1:0]  cap_eff;
  logic                       accept;
  logic                       look;
  logic                       upd;
  logic                       evict;
  logic [lkv_pkg::CNT_W-1:0]  hits_nxt;
  logic [lkv_pkg::CNT_W-1:0]  misses_nxt;

  lkv_pkg::lkv_ctrl_t ctrl;
  lkv_pkg::lkv_link_t link [lkv_pkg::N_ENTRIES+1];
  logic               taken [lkv_pkg::N_ENTRIES+1];
  lkv_pkg::lkv_stat_t stat [lkv_pkg::N_ENTRIES];
  logic [lkv_pkg::N_ENTRIES-1:0] valid_vec;
  logic [lkv_pkg::N_ENTRIES-1:0] match_vec;
  logic [lkv_pkg::N_ENTRIES-1:0] vict_vec;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      lkv_pkg::S_IDLE: if (in_tvalid) state_nxt = lkv_pkg::S_LOOK;
      lkv_pkg::S_LOOK: state_nxt = lkv_pkg::S_UPD;
      lkv_pkg::S_UPD:  if (!out_valid_r || out_tready) state_nxt = lkv_pkg::S_IDLE;
      default:         state_nxt = lkv_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    in_tready = 1'b0;
    look      = 1'b0;
    upd       = 1'b0;
    unique case (state_r)
      lkv_pkg::S_IDLE: in_tready = 1'b1;
      lkv_pkg::S_LOOK: look = 1'b1;
      lkv_pkg::S_UPD:  upd = !out_valid_r || out_tready;
      default:         in_tready = 1'b0;
    endcase
  end

  assign accept = in_tvalid && in_tready;

  always_comb begin
    priority if (cap_r == '0) begin
      cap_eff = lkv_pkg::OCC_W'(1);
    end else if (cap_r > lkv_pkg::CAP_W'(lkv_pkg::N_ENTRIES)) begin
      cap_eff = lkv_pkg::OCC_W'(lkv_pkg::N_ENTRIES);
    end else begin
      cap_eff = lkv_pkg::OCC_W'(cap_r);
    end
  end

  assign evict = put_r && !hit_r && (occ_r >= cap_eff);

  always_comb begin
    ctrl.look      = look;
    ctrl.upd       = upd;
    ctrl.put       = put_r;
    ctrl.hit       = hit_r;
    ctrl.evict     = evict;
    ctrl.key       = key_r;
    ctrl.value     = value_r;
    ctrl.last_rank = lkv_pkg::RANK_W'(occ_r - lkv_pkg::OCC_W'(1));
    ctrl.hit_rank  = hit_rank_r;
  end

  assign link[0]  = '0;
  assign taken[0] = 1'b0;

  for (genvar i = 0; i < lkv_pkg::N_ENTRIES; i++) begin : g_cell
    lkv_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .ctrl      (ctrl),
      .link_in   (link[i]),
      .link_out  (link[i+1]),
      .taken_in  (taken[i]),
      .taken_out (taken[i+1]),
      .stat      (stat[i])
    );
    assign valid_vec[i] = stat[i].valid;
    assign match_vec[i] = stat[i].match;
    assign vict_vec[i]  = stat[i].vict;
  end

  always_comb begin
    hits_nxt   = hits_r;
    misses_nxt = misses_r;
    if (!put_r) begin
      if (hit_r) begin
        if (hits_r != '1) hits_nxt = hits_r + 1'b1;
      end else begin
        if (misses_r != '1) misses_nxt = misses_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= lkv_pkg::S_IDLE;
      cap_r       <= lkv_pkg::CAP_RESET;
      occ_r       <= '0;
      hits_r      <= '0;
      misses_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_wen) cap_r <= cfg_wdata;
      if (upd) begin
        hits_r      <= hits_nxt;
        misses_r    <= misses_nxt;
        out_valid_r <= 1'b1;
        if (put_r && !hit_r && !evict) occ_r <= occ_r + 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      put_r   <= (in_tuser == lkv_pkg::FUNC_PUT);
      key_r   <= in_tdata[lkv_pkg::KEY_W-1:0];
      value_r <= in_tdata[lkv_pkg::KEY_W +: lkv_pkg::VAL_W];
    end
    if (look) begin
      hit_r      <= link[lkv_pkg::N_ENTRIES].hit;
      hit_rank_r <= link[lkv_pkg::N_ENTRIES].rank;
      rd_r       <= link[lkv_pkg::N_ENTRIES].rd;
      evk_r      <= link[lkv_pkg::N_ENTRIES].evk;
    end
    if (upd) begin
      out_user_r <= {evict, hit_r};
      out_data_r <= {misses_nxt, hits_nxt,
                     (evict ? evk_r : {lkv_pkg::KEY_W{1'b0}}),
                     ((!put_r && hit_r) ? rd_r : {lkv_pkg::VAL_W{1'b0}})};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;

`ifndef SYNTHESIS
  a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
    occ_r <= lkv_pkg::OCC_W'(lkv_pkg::N_ENTRIES))
    else $error("occupancy exceeds the number of cells");

  a_occ_count: assert property (@(posedge clk) disable iff (!rst_n)
    $countones(valid_vec) == int'(occ_r))
    else $error("occupancy disagrees with the valid cells");

  a_one_match: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == lkv_pkg::S_UPD) |-> $onehot0(match_vec & valid_vec))
    else $error("key found in more than one cell");

  a_one_victim: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == lkv_pkg::S_UPD && evict) |-> $onehot(vict_vec & valid_vec))
    else $error("eviction without exactly one least recent cell");

  a_result_after_update: assert property (@(posedge clk) disable iff (!rst_n)
    upd |=> out_valid_r && state_r == lkv_pkg::S_IDLE)
    else $error("update did not present a result");
`endif

endmodule

@@ sim/lru_key_value_cache_tb.sv @@
`timescale 1ns / 100ps

module lru_key_value_cache_tb;

  localparam int CYCLE_LIMIT = 400000;
  localparam int POOL_SIZE   = 40;
  localparam int IDLE_PCT    = 30;

  typedef struct {
    bit                      hit;
    bit [lkv_pkg::VAL_W-1:0] read_value;
    bit                      evicted;
    bit [lkv_pkg::KEY_W-1:0] evicted_key;
    bit [lkv_pkg::CNT_W-1:0] hits_total;
    bit [lkv_pkg::CNT_W-1:0] misses_total;
  } lookup_result_t;

  logic                           clk       = 1'b0;
  logic                           rst_n     = 1'b0;
  logic                           cfg_wen   = 1'b0;
  logic [lkv_pkg::CAP_W-1:0]      cfg_wdata = '0;
  logic                           in_tvalid = 1'b0;
  logic                           in_tready;
  logic [lkv_pkg::IN_DATA_W-1:0]  in_tdata  = '0;
  logic                           in_tuser  = 1'b0;
  logic                           out_tvalid;
  logic                           out_tready = 1'b0;
  logic [lkv_pkg::OUT_DATA_W-1:0] out_tdata;
  logic [lkv_pkg::OUT_USER_W-1:0] out_tuser;

  bit [lkv_pkg::KEY_W-1:0] slot_key   [lkv_pkg::N_ENTRIES];
  bit [lkv_pkg::VAL_W-1:0] slot_value [lkv_pkg::N_ENTRIES];
  bit                      slot_used  [lkv_pkg::N_ENTRIES];
  int unsigned             slot_age   [lkv_pkg::N_ENTRIES];
  int unsigned             fill_level;
  bit [lkv_pkg::CNT_W-1:0] hit_count;
  bit [lkv_pkg::CNT_W-1:0] miss_count;
  bit [lkv_pkg::CAP_W-1:0] capacity_reg;

  lookup_result_t          pending_results[$];
  lookup_result_t          oldest;
  bit [lkv_pkg::KEY_W-1:0] key_pool [POOL_SIZE];
  int                      errors = 0;
  int unsigned             cycles = 0;
  bit                      steady = 1'b0;

  lru_key_value_cache i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wen    (cfg_wen),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    out_tready <= steady || ($urandom_range(99) >= IDLE_PCT);
  end

  initial begin
    wait (cycles >= CYCLE_LIMIT);
    $display("lru_key_value_cache: mismatch");
    $finish;
  end

  function automatic void reset_model();
    for (int i = 0; i < lkv_pkg::N_ENTRIES; i++) begin
      slot_key[i]   = '0;
      slot_value[i] = '0;
      slot_used[i]  = 1'b0;
      slot_age[i]   = 0;
    end
    fill_level   = 0;
    hit_count    = '0;
    miss_count   = '0;
    capacity_reg = lkv_pkg::CAP_RESET;
  endfunction

  function automatic void promote_slot(int s);
    int unsigned r = slot_age[s];
    for (int i = 0; i < lkv_pkg::N_ENTRIES; i++) begin
      if (slot_used[i] && slot_age[i] < r) slot_age[i]++;
    end
    slot_age[s] = 0;
  endfunction

  function automatic lookup_result_t cache_model_access(lkv_pkg::func_t op,
                                                        bit [lkv_pkg::KEY_W-1:0] key,
                                                        bit [lkv_pkg::VAL_W-1:0] value);
    lookup_result_t res;
    int             found  = -1;
    int             victim = -1;
    int             slot   = -1;
    int unsigned    eff_cap;
    res = '{default: 0};
    for (int i = 0; i < lkv_pkg::N_ENTRIES; i++) begin
      if (found < 0 && slot_used[i] && slot_key[i] == key) found = i;
    end
    if (op == lkv_pkg::FUNC_GET) begin
      if (found >= 0) begin
        res.hit = 1'b1;
        res.read_value = slot_value[found];
        promote_slot(found);
        if (hit_count != '1) hit_count++;
      end else if (miss_count != '1) begin
        miss_count++;
      end
    end else if (found >= 0) begin
      res.hit = 1'b1;
      slot_value[found] = value;
      promote_slot(found);
    end else begin
      eff_cap = (capacity_reg == 0) ? 1 : capacity_reg;
      if (eff_cap > lkv_pkg::N_ENTRIES) eff_cap = lkv_pkg::N_ENTRIES;
      if (fill_level >= eff_cap) begin
        for (int i = 0; i < lkv_pkg::N_ENTRIES; i++) begin
          if (slot_used[i] && (victim < 0 || slot_age[i] > slot_age[victim])) victim = i;
        end
        if (victim >= 0) begin
          res.evicted = 1'b1;
          res.evicted_key = slot_key[victim];
          slot_used[victim] = 1'b0;
          slot_age[victim] = 0;
          fill_level--;
        end
      end
      for (int i = 0; i < lkv_pkg::N_ENTRIES; i++) begin
        if (slot < 0 && !slot_used[i]) slot = i;
      end
      if (slot >= 0) begin
        for (int i = 0; i < lkv_pkg::N_ENTRIES; i++) begin
          if (slot_used[i]) slot_age[i]++;
        end
        slot_used[slot]  = 1'b1;
        slot_key[slot]   = key;
        slot_value[slot] = value;
        slot_age[slot]   = 0;
        fill_level++;
      end
    end
    res.hits_total   = hit_count;
    res.misses_total = miss_count;
    return res;
  endfunction

  task automatic check_field(string name, bit [63:0] expected, logic [63:0] actual);
    if (actual !== expected) begin
      $error("%s: expected %0h, got %0h", name, expected, actual);
      errors++;
    end
  endtask

  // Output signals are stable from the falling edge up to the rising edge that
  // completes the transaction, so the check samples them at the falling edge.
  always @(negedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_results.size() == 0) begin
        $error("unexpected transaction on the output channel");
        errors++;
      end else begin
        oldest = pending_results.pop_front();
        check_field("hit", oldest.hit, out_tuser[0]);
        check_field("evicted", oldest.evicted, out_tuser[1]);
        check_field("read_value", oldest.read_value, out_tdata[63:0]);
        check_field("evicted_key", oldest.evicted_key, out_tdata[127:64]);
        check_field("hits_total", oldest.hits_total, out_tdata[159:128]);
        check_field("misses_total", oldest.misses_total, out_tdata[191:160]);
      end
    end
  end

  task automatic issue_request(lkv_pkg::func_t op, bit [lkv_pkg::KEY_W-1:0] key,
                               bit [lkv_pkg::VAL_W-1:0] value);
    bit taken;
    while (!steady && $urandom_range(99) < IDLE_PCT) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= {value, key};
    do begin
      @(negedge clk);
      taken = in_tready;
      @(posedge clk);
    end while (!taken);
    pending_results.insert(pending_results.size(), cache_model_access(op, key, value));
  endtask

  task automatic write_capacity(bit [lkv_pkg::CAP_W-1:0] cap);
    in_tvalid <= 1'b0;
    wait (pending_results.size() == 0);
    repeat (4) @(posedge clk);
    cfg_wen   <= 1'b1;
    cfg_wdata <= cap;
    @(posedge clk);
    cfg_wen <= 1'b0;
    capacity_reg = cap;
  endtask

  task automatic test_lookup_basics();
    issue_request(lkv_pkg::FUNC_GET, '0, '1);
    issue_request(lkv_pkg::FUNC_PUT, '0, '0);
    issue_request(lkv_pkg::FUNC_PUT, '1, '1);
    issue_request(lkv_pkg::FUNC_GET, '0, '0);
    issue_request(lkv_pkg::FUNC_GET, '1, '0);
    issue_request(lkv_pkg::FUNC_PUT, '0, 64'h5555_5555_5555_5555);
    issue_request(lkv_pkg::FUNC_GET, '0, '1);
    issue_request(lkv_pkg::FUNC_GET, 64'hAAAA_AAAA_AAAA_AAAA, '0);
  endtask

  task automatic test_capacity_limits();
    write_capacity(5'd0);
    issue_request(lkv_pkg::FUNC_PUT, key_pool[2], 64'h0123_4567_89AB_CDEF);
    issue_request(lkv_pkg::FUNC_PUT, key_pool[3], 64'hFEDC_BA98_7654_3210);
    issue_request(lkv_pkg::FUNC_GET, key_pool[2], '0);
    write_capacity(5'd31);
    for (int i = 4; i < 8; i++) begin
      issue_request(lkv_pkg::FUNC_PUT, key_pool[i], {$urandom, $urandom});
    end
    write_capacity(5'd2);
    issue_request(lkv_pkg::FUNC_PUT, key_pool[8], {$urandom, $urandom});
    issue_request(lkv_pkg::FUNC_GET, key_pool[7], '0);
    write_capacity(5'd1);
    issue_request(lkv_pkg::FUNC_PUT, key_pool[9], {$urandom, $urandom});
    issue_request(lkv_pkg::FUNC_GET, key_pool[9], '0);
    write_capacity(5'd17);
    issue_request(lkv_pkg::FUNC_PUT, key_pool[10], {$urandom, $urandom});
  endtask

  task automatic test_random_traffic();
    bit [lkv_pkg::CAP_W-1:0] caps [10] = '{5'd16, 5'd1, 5'd31, 5'd5, 5'd0,
                                           5'd12, 5'd17, 5'd3, 5'd16, 5'd8};
    int                      span;
    int                      base;
    bit [lkv_pkg::KEY_W-1:0] key;
    for (int p = 0; p < 10; p++) begin
      write_capacity(caps[p]);
      steady = (p == 8);
      span = ((caps[p] == 0) ? 1 :
              (caps[p] > lkv_pkg::N_ENTRIES ? lkv_pkg::N_ENTRIES : caps[p])) + 6;
      for (int n = 0; n < 123; n++) begin
        base = $urandom_range(POOL_SIZE - span);
        if ($urandom_range(99) < 90) key = key_pool[base + $urandom_range(span - 1)];
        else key = {$urandom, $urandom};
        issue_request(lkv_pkg::func_t'($urandom_range(1)), key, {$urandom, $urandom});
      end
    end
    steady = 1'b0;
  endtask

  initial begin
    reset_model();
    key_pool[0] = '0;
    key_pool[1] = '1;
    for (int i = 2; i < POOL_SIZE; i++) key_pool[i] = {$urandom, $urandom};
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_lookup_basics();
    test_capacity_limits();
    test_random_traffic();
    in_tvalid <= 1'b0;
    wait (pending_results.size() == 0);
    repeat (20) @(posedge clk);
    if (errors == 0) begin
      $display("lru_key_value_cache: match");
    end else begin
      $display("lru_key_value_cache: mismatch");
    end
    $finish;
  end

endmodule

@@ files.f @@
design/lkv_pkg.sv
design/lkv_cell.sv
design/lru_key_value_cache.sv
sim/lru_key_value_cache_tb.sv
